// ===== rtl/qvr_pkg.sv =====
// Package with shared constants and types for the quaternion vector rotation block.
`timescale 1ns / 1ps

package qvr_pkg;

    // Register indexes of the configuration port.
    localparam logic [7:0] REG_QUAT_X = 8'd0;
    localparam logic [7:0] REG_QUAT_Y = 8'd1;
    localparam logic [7:0] REG_QUAT_Z = 8'd2;
    localparam logic [7:0] REG_QUAT_W = 8'd3;

    localparam logic signed [15:0] QUAT_W_RESET = 16'sd16384;

    // One root bit per square-root stage, one quotient bit per divider stage.
    localparam int SQRT_STEPS = 30;
    localparam int DIV_STEPS  = 16;

    // Per-vector information that travels beside the root and quotient.
    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][15:0] mag;
    } side_t;

endpackage

// ===== rtl/quaternion_vector_rotation.sv =====
// Top level: pipelined normalisation and quaternion rotation of a vector stream.
`timescale 1ns / 1ps

// Takes one vector per cycle and returns one rotated unit vector per cycle while the output
// side does not stall. A vector passes through the input, square and norm registers, the
// square-root pipeline (a load stage and 30 stages, one root bit each), the divider pipeline
// (a load stage and 16 stages, one quotient bit each, three components side by side), the
// sign stage, the three registered multiply-and-add stages of the quaternion products, and
// the rounding and saturation registers. The whole pipeline advances together; it holds
// when a result waits at the output and the sink is not ready.
// The quaternion registers are read directly by the multipliers, so the user must see that
// they are written only while no vector is in flight; the block itself does not enforce this.
// A zero vector gives zero outputs with tuser set.
module quaternion_vector_rotation
    import qvr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // vec_x [15:0], vec_y [31:16], vec_z [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // rot_x [15:0], rot_y [31:16], rot_z [47:32]
    output logic        m_tuser    // zero_vector [0]
);

    logic signed [15:0] quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;

    logic en;

    // Stage valids.
    logic                  v0_reg, v1_reg, v2_reg, v3_reg, dvi_valid_reg, sg_valid_reg;
    logic                  m1_valid_reg, a1_valid_reg, m2_valid_reg, a2_valid_reg;
    logic                  out_valid_reg;
    logic [SQRT_STEPS-1:0] sq_valid_reg;
    logic [DIV_STEPS-1:0]  dv_valid_reg;

    // Squares and norm.
    logic signed [15:0] x0_reg, y0_reg, z0_reg;
    logic [30:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [31:0]        n2_reg;
    side_t              side1_reg;
    side_t              side2_reg;

    // Square-root pipeline; entry 0 is loaded from the norm stage.
    logic [59:0] sq_rad_reg  [0:SQRT_STEPS];
    logic [31:0] sq_rem_reg  [0:SQRT_STEPS];
    logic [29:0] sq_root_reg [0:SQRT_STEPS];
    side_t       sq_side_reg [0:SQRT_STEPS];
    logic [59:0] sq_rad_next  [0:SQRT_STEPS-1];
    logic [31:0] sq_rem_next  [0:SQRT_STEPS-1];
    logic [29:0] sq_root_next [0:SQRT_STEPS-1];

    // Divider pipeline; entry 0 is loaded from the divider set-up stage.
    logic [2:0][31:0] dv_rem_reg  [0:DIV_STEPS];
    logic [2:0][15:0] dv_low_reg  [0:DIV_STEPS];
    logic [2:0][15:0] dv_q_reg    [0:DIV_STEPS];
    logic [30:0]      dv_den_reg  [0:DIV_STEPS];
    side_t            dv_side_reg [0:DIV_STEPS];
    logic [2:0][31:0] dv_rem_next [0:DIV_STEPS-1];
    logic [2:0][15:0] dv_low_next [0:DIV_STEPS-1];
    logic [2:0][15:0] dv_q_next   [0:DIV_STEPS-1];
    logic [2:0][31:0] dvi_rem;
    logic [2:0][15:0] dvi_low;

    // Signed unit vector and the two product rounds.
    logic signed [16:0] ux_reg, uy_reg, uz_reg;
    logic               zero_u_reg, zero_m1_reg, zero_a1_reg, zero_m2_reg, zero_a2_reg;
    logic signed [32:0] m1_reg [0:11];
    logic signed [34:0] tw_reg, tx_reg, ty_reg, tz_reg;
    logic signed [50:0] m2_reg [0:11];
    logic signed [52:0] rx_sum, ry_sum, rz_sum;
    logic signed [24:0] fx_reg, fy_reg, fz_reg;
    logic [47:0]        out_data_reg;
    logic               out_zero_reg;

    function automatic logic [15:0] sat16(input logic signed [24:0] v);
        logic [15:0] res;
        if (v > 25'sd32767)
            res = 16'h7FFF;
        else if (v < -25'sd32768)
            res = 16'h8000;
        else
            res = v[15:0];
        return res;
    endfunction

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
            quat_w_reg <= QUAT_W_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_QUAT_X: quat_x_reg <= cfg_data;
                REG_QUAT_Y: quat_y_reg <= cfg_data;
                REG_QUAT_Z: quat_z_reg <= cfg_data;
                REG_QUAT_W: quat_w_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            sq_valid_reg  <= '0;
            dvi_valid_reg <= 1'b0;
            dv_valid_reg  <= '0;
            sg_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            a1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            a2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= s_tvalid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            sq_valid_reg  <= {sq_valid_reg[SQRT_STEPS-2:0], v3_reg};
            dvi_valid_reg <= sq_valid_reg[SQRT_STEPS-1];
            dv_valid_reg  <= {dv_valid_reg[DIV_STEPS-2:0], dvi_valid_reg};
            sg_valid_reg  <= dv_valid_reg[DIV_STEPS-1];
            m1_valid_reg  <= sg_valid_reg;
            a1_valid_reg  <= m1_valid_reg;
            m2_valid_reg  <= a1_valid_reg;
            a2_valid_reg  <= m2_valid_reg;
            out_valid_reg <= a2_valid_reg;
        end
    end

    // One root bit per stage: bring down two radicand bits and try (root << 2) | 1.
    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            logic [33:0] acc;
            logic [33:0] trial;
            acc   = {sq_rem_reg[k], sq_rad_reg[k][59:58]};
            trial = {2'b00, sq_root_reg[k], 2'b01};
            sq_rad_next[k] = {sq_rad_reg[k][57:0], 2'b00};
            if (acc >= trial)
            begin
                sq_rem_next[k]  = 32'(acc - trial);
                sq_root_next[k] = {sq_root_reg[k][28:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = acc[31:0];
                sq_root_next[k] = {sq_root_reg[k][28:0], 1'b0};
            end
        end
    end

    // Divider set-up: numerator (mag << 29) + r over 2r; the quotient fits 16 bits.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [44:0] num;
            num = {sq_side_reg[SQRT_STEPS].mag[c], 29'd0}
                + {15'd0, sq_root_reg[SQRT_STEPS]};
            dvi_rem[c] = {3'd0, num[44:16]};
            dvi_low[c] = num[15:0];
        end
    end

    // One quotient bit per stage, restoring division on all three components.
    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic [31:0] t;
                t = {dv_rem_reg[k][c][30:0], dv_low_reg[k][c][15]};
                dv_low_next[k][c] = {dv_low_reg[k][c][14:0], 1'b0};
                if (t >= {1'b0, dv_den_reg[k]})
                begin
                    dv_rem_next[k][c] = t - {1'b0, dv_den_reg[k]};
                    dv_q_next[k][c]   = {dv_q_reg[k][c][14:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[k][c] = t;
                    dv_q_next[k][c]   = {dv_q_reg[k][c][14:0], 1'b0};
                end
            end
        end
    end

    assign rx_sum = 53'(m2_reg[0]) + 53'(m2_reg[1]) + 53'(m2_reg[2]) - 53'(m2_reg[3])
                  + 53'sd134217728;
    assign ry_sum = 53'(m2_reg[4]) + 53'(m2_reg[5]) + 53'(m2_reg[6]) - 53'(m2_reg[7])
                  + 53'sd134217728;
    assign rz_sum = 53'(m2_reg[8]) + 53'(m2_reg[9]) + 53'(m2_reg[10]) - 53'(m2_reg[11])
                  + 53'sd134217728;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Squares.
            x0_reg  <= s_tdata[15:0];
            y0_reg  <= s_tdata[31:16];
            z0_reg  <= s_tdata[47:32];
            sqx_reg <= 31'(unsigned'(32'(x0_reg * x0_reg)));
            sqy_reg <= 31'(unsigned'(32'(y0_reg * y0_reg)));
            sqz_reg <= 31'(unsigned'(32'(z0_reg * z0_reg)));

            // Norm squared, magnitudes and signs.
            n2_reg            <= {1'b0, sqx_reg} + {1'b0, sqy_reg} + {1'b0, sqz_reg};
            side1_reg.neg     <= {z0_reg[15], y0_reg[15], x0_reg[15]};
            side1_reg.mag[0]  <= x0_reg[15] ? 16'(-x0_reg) : x0_reg;
            side1_reg.mag[1]  <= y0_reg[15] ? 16'(-y0_reg) : y0_reg;
            side1_reg.mag[2]  <= z0_reg[15] ? 16'(-z0_reg) : z0_reg;
            side1_reg.zero    <= (x0_reg == '0) && (y0_reg == '0) && (z0_reg == '0);
            side2_reg         <= side1_reg;

            // Square root of n2 << 28.
            sq_rad_reg[0]  <= {n2_reg, 28'd0};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= side2_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                sq_rad_reg[k+1]  <= sq_rad_next[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end

            // Division.
            dv_rem_reg[0]  <= dvi_rem;
            dv_low_reg[0]  <= dvi_low;
            dv_q_reg[0]    <= '0;
            dv_den_reg[0]  <= {sq_root_reg[SQRT_STEPS], 1'b0};
            dv_side_reg[0] <= sq_side_reg[SQRT_STEPS];
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_rem_reg[k+1]  <= dv_rem_next[k];
                dv_low_reg[k+1]  <= dv_low_next[k];
                dv_q_reg[k+1]    <= dv_q_next[k];
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end

            // Signed unit vector.
            ux_reg <= dv_side_reg[DIV_STEPS].neg[0] ? -$signed({1'b0, dv_q_reg[DIV_STEPS][0]})
                                                    : $signed({1'b0, dv_q_reg[DIV_STEPS][0]});
            uy_reg <= dv_side_reg[DIV_STEPS].neg[1] ? -$signed({1'b0, dv_q_reg[DIV_STEPS][1]})
                                                    : $signed({1'b0, dv_q_reg[DIV_STEPS][1]});
            uz_reg <= dv_side_reg[DIV_STEPS].neg[2] ? -$signed({1'b0, dv_q_reg[DIV_STEPS][2]})
                                                    : $signed({1'b0, dv_q_reg[DIV_STEPS][2]});
            zero_u_reg <= dv_side_reg[DIV_STEPS].zero;

            // t = v * conj(q): products.
            m1_reg[0]  <= 33'(ux_reg * quat_x_reg);
            m1_reg[1]  <= 33'(uy_reg * quat_y_reg);
            m1_reg[2]  <= 33'(uz_reg * quat_z_reg);
            m1_reg[3]  <= 33'(ux_reg * quat_w_reg);
            m1_reg[4]  <= 33'(uy_reg * quat_z_reg);
            m1_reg[5]  <= 33'(uz_reg * quat_y_reg);
            m1_reg[6]  <= 33'(uy_reg * quat_w_reg);
            m1_reg[7]  <= 33'(uz_reg * quat_x_reg);
            m1_reg[8]  <= 33'(ux_reg * quat_z_reg);
            m1_reg[9]  <= 33'(uz_reg * quat_w_reg);
            m1_reg[10] <= 33'(ux_reg * quat_y_reg);
            m1_reg[11] <= 33'(uy_reg * quat_x_reg);
            zero_m1_reg <= zero_u_reg;

            // t = v * conj(q): sums.
            tw_reg <= 35'(m1_reg[0]) + 35'(m1_reg[1]) + 35'(m1_reg[2]);
            tx_reg <= 35'(m1_reg[3]) - 35'(m1_reg[4]) + 35'(m1_reg[5]);
            ty_reg <= 35'(m1_reg[6]) - 35'(m1_reg[7]) + 35'(m1_reg[8]);
            tz_reg <= 35'(m1_reg[9]) - 35'(m1_reg[10]) + 35'(m1_reg[11]);
            zero_a1_reg <= zero_m1_reg;

            // q * t, vector part: products.
            m2_reg[0]  <= 51'(quat_w_reg * tx_reg);
            m2_reg[1]  <= 51'(quat_x_reg * tw_reg);
            m2_reg[2]  <= 51'(quat_y_reg * tz_reg);
            m2_reg[3]  <= 51'(quat_z_reg * ty_reg);
            m2_reg[4]  <= 51'(quat_w_reg * ty_reg);
            m2_reg[5]  <= 51'(quat_y_reg * tw_reg);
            m2_reg[6]  <= 51'(quat_z_reg * tx_reg);
            m2_reg[7]  <= 51'(quat_x_reg * tz_reg);
            m2_reg[8]  <= 51'(quat_w_reg * tz_reg);
            m2_reg[9]  <= 51'(quat_z_reg * tw_reg);
            m2_reg[10] <= 51'(quat_x_reg * ty_reg);
            m2_reg[11] <= 51'(quat_y_reg * tx_reg);
            zero_m2_reg <= zero_a1_reg;

            // Sums with the half added, then a floor shift back to Q1.14.
            fx_reg <= 25'(rx_sum >>> 28);
            fy_reg <= 25'(ry_sum >>> 28);
            fz_reg <= 25'(rz_sum >>> 28);
            zero_a2_reg <= zero_m2_reg;

            // Saturation; a zero vector forces zero outputs.
            out_data_reg <= zero_a2_reg ? '0 : {sat16(fz_reg), sat16(fy_reg), sat16(fx_reg)};
            out_zero_reg <= zero_a2_reg;
        end
    end

    a_zero_flag_clears_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero_vector result carries non-zero data");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while the pipeline is held");

    a_output_from_pipeline: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(a2_valid_reg))
        else $error("result appeared without an item in the last stage");

endmodule
